>>> hw/rtl/rpmd_pkg.sv
// rpmd_pkg: shared types and constants of the row profile minimum detector
// pixel and line transaction structs, config register codes, field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpmd_pkg;

  localparam int unsigned PixelW  = 8;
  localparam int unsigned RowW    = 12;
  localparam int unsigned EnergyW = 20;
  localparam int unsigned SpanW   = 13;
  localparam int unsigned ThreshW = 8;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned LimitW  = SpanW + ThreshW;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [SpanW-1:0]   SpanReset   = SpanW'(1);
  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(64);
  localparam logic [EnergyW-1:0] EnergyMax   = {EnergyW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPAN_WIDTH     = 1'b0,
    CFG_DARK_THRESHOLD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic [RowW-1:0]   row_y;
    logic              row_end;
    logic              frame_start;
  } pixel_t;

  typedef struct packed {
    logic [RowW-1:0]    line_row;
    logic [EnergyW-1:0] line_energy;
  } line_t;

endpackage

`default_nettype wire

>>> hw/rtl/row_profile_minimum_detector.sv
// row_profile_minimum_detector: row energy profile and dark line detection
// depends on rpmd_pkg (transaction structs, config codes, widths)
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   pixel_t
//   out      output     out_valid_o / out_stall_i line_t
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one pixel per cycle sustained unless a result meets a stalled output; a pixel is
// captured in the input register and, as it leaves, updates the row sums and the result register.
// the threshold limit (threshold times span width) is a registered product
// refreshed every cycle from the config registers.
// reset clears row history and loads span width 1, threshold 64.
// a stalled output only holds back pixels that would produce a result.
`timescale 1ns / 1ps
`default_nettype none

module row_profile_minimum_detector
  import rpmd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire pixel_t              in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output line_t                    out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [SpanW-1:0]    cfg_data_i
);

  logic [SpanW-1:0]   span_q;
  logic [ThreshW-1:0] thresh_q;
  logic [LimitW-1:0]  limit_q;

  logic               s1_valid_q;
  pixel_t             s1_q;

  logic [EnergyW-1:0] acc_q, acc_d;
  logic [EnergyW-1:0] prev_sum_q, older_sum_q;
  logic [RowW-1:0]    prev_row_q;
  logic [1:0]         rows_seen_q, rows_seen_d;

  logic               out_valid_q, out_valid_d;
  line_t              out_q;

  logic [LevelW-1:0]    level;
  logic [2*LevelW-1:0]  square;
  logic [EnergyW-1:0]   acc_base;
  logic [EnergyW:0]     sum_wide;
  logic [EnergyW-1:0]   row_sum;
  logic [1:0]           rows_base;
  logic                 hit;
  logic                 out_free;
  logic                 s1_go;
  logic                 s1_fire;
  logic                 in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q   <= SpanReset;
      thresh_q <= ThreshReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SPAN_WIDTH:     span_q   <= cfg_data_i;
        CFG_DARK_THRESHOLD: thresh_q <= cfg_data_i[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q <= LimitW'(span_q) * LimitW'(thresh_q);
  end

  // per-pixel energy and the three-row minimum test
  always_comb begin
    level     = s1_q.pixel[PixelW-1 -: LevelW];
    square    = {{LevelW{1'b0}}, level} * {{LevelW{1'b0}}, level};
    acc_base  = s1_q.frame_start ? '0 : acc_q;
    rows_base = s1_q.frame_start ? 2'd0 : rows_seen_q;
    sum_wide  = (EnergyW+1)'(acc_base) + (EnergyW+1)'(square);
    row_sum   = sum_wide[EnergyW] ? EnergyMax : sum_wide[EnergyW-1:0];
    hit       = s1_q.row_end && (rows_base == 2'd2) &&
                (prev_sum_q < older_sum_q) && (prev_sum_q < row_sum) &&
                (LimitW'(prev_sum_q) < limit_q);
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = !hit || out_free;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    acc_d       = row_sum;
    rows_seen_d = rows_base;
    if (s1_q.row_end) begin
      acc_d = '0;
      if (rows_base != 2'd2) begin
        rows_seen_d = rows_base + 2'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && hit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      prev_sum_q  <= '0;
      older_sum_q <= '0;
      prev_row_q  <= '0;
      rows_seen_q <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        acc_q       <= acc_d;
        rows_seen_q <= rows_seen_d;
        if (s1_q.row_end) begin
          older_sum_q <= prev_sum_q;
          prev_sum_q  <= row_sum;
          prev_row_q  <= s1_q.row_y;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (s1_fire && hit) begin
      out_q.line_row    <= prev_row_q;
      out_q.line_energy <= prev_sum_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // row counter saturates at two finished rows
  a_rows_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_seen_q != 2'd3)
    else $error("rows_seen overflow");

  // a new line transaction only comes from a pixel leaving stage one
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("line transaction without a pixel");

  // back pressure only while a pixel is held in stage one
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty stage");

  // a row end restarts the row sum
  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_q.row_end) |=> (acc_q == '0))
    else $error("row sum not cleared at row end");

endmodule

`default_nettype wire

>>> dv/row_profile_minimum_detector_test.sv
// row_profile_minimum_detector_test: self-checking bench for the dark line detector
// predicts row energy minima from accepted pixels and checks every line transaction
// depends on rpmd_pkg and row_profile_minimum_detector
`timescale 1ns / 1ps

module row_profile_minimum_detector_test;
  import rpmd_pkg::*;

  localparam int unsigned SettleCycles = 6;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned HoldCycles   = 400;

  // tracks row sums of the stream and queues the dark lines it must report
  class dark_line_scoreboard;
    logic [SpanW-1:0]   span_width;
    logic [ThreshW-1:0] dark_threshold;
    logic [EnergyW-1:0] row_energy;
    logic [EnergyW-1:0] last_energy;
    logic [EnergyW-1:0] older_energy;
    logic [RowW-1:0]    last_row;
    int unsigned        finished_rows;
    line_t              expected_lines[$];
    int unsigned        mismatches;

    function new();
      span_width     = SpanReset;
      dark_threshold = ThreshReset;
      row_energy     = '0;
      last_energy    = '0;
      older_energy   = '0;
      last_row       = '0;
      finished_rows  = 0;
      mismatches     = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [SpanW-1:0] data);
      case (idx)
        CFG_SPAN_WIDTH: begin
          span_width = data;
        end
        CFG_DARK_THRESHOLD: begin
          dark_threshold = data[ThreshW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void record_pixel(pixel_t px);
      logic [7:0]         square;
      logic [EnergyW:0]   total;
      logic [LimitW-1:0]  limit;
      line_t              hit;
      square = {4'b0, px.pixel[7:4]} * {4'b0, px.pixel[7:4]};
      if (px.frame_start) begin
        row_energy    = '0;
        finished_rows = 0;
      end
      total = {1'b0, row_energy} + square;
      if (total > EnergyMax) begin
        total = EnergyMax;
      end
      row_energy = total[EnergyW-1:0];
      if (px.row_end) begin
        if (finished_rows >= 2) begin
          limit = LimitW'(dark_threshold) * LimitW'(span_width);
          if (last_energy < older_energy && last_energy < row_energy &&
              {1'b0, last_energy} < limit) begin
            hit.line_row    = last_row;
            hit.line_energy = last_energy;
            expected_lines  = {expected_lines, hit};
          end
        end
        older_energy = last_energy;
        last_energy  = row_energy;
        last_row     = px.row_y;
        if (finished_rows < 2) begin
          finished_rows++;
        end
        row_energy = '0;
      end
    endfunction

    function void check_line(line_t got);
      line_t want;
      if (expected_lines.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected line expected none got row %0h energy %0d",
                 $time, got.line_row, got.line_energy);
        return;
      end
      want = expected_lines.pop_front();
      if (got.line_row !== want.line_row) begin
        mismatches++;
        $display("%0t: line_row expected %0h got %0h", $time, want.line_row, got.line_row);
      end
      if (got.line_energy !== want.line_energy) begin
        mismatches++;
        $display("%0t: line_energy expected %0d got %0d",
                 $time, want.line_energy, got.line_energy);
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        pix_valid  = 1'b0;
  logic        pix_stall;
  pixel_t      pix_data   = '0;
  logic        line_valid;
  logic        line_stall = 1'b0;
  line_t       line_data;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  cfg_reg_e    cfg_index  = CFG_SPAN_WIDTH;
  logic [SpanW-1:0] cfg_data = '0;

  int unsigned gap_pct      = 19;
  int unsigned stall_pct    = 87;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;

  dark_line_scoreboard lines_sb = new();

  row_profile_minimum_detector u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (pix_valid),
    .in_stall_o  (pix_stall),
    .in_data_i   (pix_data),
    .out_valid_o (line_valid),
    .out_stall_i (line_stall),
    .out_data_o  (line_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      line_stall <= 1'b1;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HoldCycles;
      line_stall <= 1'b1;
    end else begin
      line_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // handshake inputs settle after the rising edge, so the transaction is known here
  always @(negedge clk) begin
    if (rst_n && line_valid && !line_stall) begin
      lines_sb.check_line(line_data);
    end
  end

  function automatic pixel_t make_pixel(logic [PixelW-1:0] value, logic [RowW-1:0] y,
                                        logic last, logic first);
    pixel_t px;
    px.pixel       = value;
    px.row_y       = y;
    px.row_end     = last;
    px.frame_start = first;
    return px;
  endfunction

  task automatic offer_pixel(input pixel_t px);
    while ($urandom_range(99) < gap_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= px;
    do @(negedge clk); while (pix_stall);
    lines_sb.record_pixel(px);
    @(posedge clk);
  endtask

  task automatic send_row(input int unsigned len, input logic [3:0] level,
                          input logic [RowW-1:0] y, input bit first_of_frame);
    pixel_t px;
    for (int unsigned i = 0; i < len; i++) begin
      px.pixel       = {level, 4'($urandom)};
      px.row_y       = (i == len - 1) ? y : RowW'($urandom);
      px.row_end     = (i == len - 1);
      px.frame_start = first_of_frame && (i == 0);
      offer_pixel(px);
    end
  endtask

  // mostly well formed frames, with one pick in ten a random noise pixel instead of a row
  task automatic send_frames(input int unsigned n_items, input int unsigned max_len);
    int unsigned     sent;
    int unsigned     len;
    int unsigned     rows_left;
    bit              fresh;
    logic [RowW-1:0] y;
    pixel_t          noise;
    sent      = 0;
    rows_left = 0;
    y         = '0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        noise.pixel       = PixelW'($urandom);
        noise.row_y       = RowW'($urandom);
        noise.row_end     = 1'($urandom);
        noise.frame_start = 1'($urandom);
        offer_pixel(noise);
        sent++;
      end else begin
        len   = $urandom_range(1, max_len);
        fresh = (rows_left == 0);
        if (fresh) begin
          rows_left = $urandom_range(3, 9);
          y         = RowW'($urandom);
        end
        // some frames carry no frame start, so history runs on across them
        send_row(len, 4'($urandom), y, fresh && ($urandom_range(4) != 0));
        rows_left--;
        y++;
        sent += len;
      end
    end
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    while (lines_sb.expected_lines.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [SpanW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    lines_sb.set_register(idx, data);
    @(posedge clk);
  endtask

  task automatic configure(input logic [SpanW-1:0] span, input logic [SpanW-1:0] thresh_word);
    drain();
    write_register(CFG_SPAN_WIDTH, span);
    write_register(CFG_DARK_THRESHOLD, thresh_word);
    cfg_valid <= 1'b0;
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: span 1, threshold 64, one-pixel rows give sums of level squared
    offer_pixel(make_pixel(8'hFF, 12'h000, 1'b1, 1'b1));  // frame start on a row end
    offer_pixel(make_pixel(8'h70, 12'h001, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'hFF, 12'h002, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'h80, 12'h003, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'hFF, 12'h004, 1'b1, 1'b0));  // row end that tests row 003, whose sum equals the limit
    offer_pixel(make_pixel(8'h7F, 12'hFFF, 1'b0, 1'b0));
    offer_pixel(make_pixel(8'h0F, 12'h005, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'hFF, 12'h006, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'h00, 12'h007, 1'b1, 1'b1));
    offer_pixel(make_pixel(8'hFF, 12'h008, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'h00, 12'h009, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'hFF, 12'h00A, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'h00, 12'h00B, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'h00, 12'h00C, 1'b1, 1'b0));  // equal neighbors
    offer_pixel(make_pixel(8'hFF, 12'h555, 1'b0, 1'b1));  // frame start mid row
    offer_pixel(make_pixel(8'h10, 12'hFFF, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'h00, 12'h800, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'hEF, 12'h7FF, 1'b1, 1'b0));

    // zero span width with threshold above 225: nothing may pass
    configure(13'd0, 13'h1FFF);
    offer_pixel(make_pixel(8'hFF, 12'h001, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'h00, 12'h002, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'hFF, 12'h003, 1'b1, 1'b0));

    configure(13'h1FFF, 13'h00FF);
    offer_pixel(make_pixel(8'h00, 12'h004, 1'b1, 1'b0));
    offer_pixel(make_pixel(8'hFF, 12'h005, 1'b1, 1'b0));

    configure(13'd8, {5'($urandom), 8'd64});
    send_frames(350, 8);

    gap_pct   = 87;
    stall_pct = 19;
    configure(SpanW'($urandom_range(1, 16)), SpanW'($urandom));
    send_frames(350, 8);

    configure(13'd4096, 13'd0);
    send_frames(100, 8);

    // short rows, loose limit: many lines while the receiver holds off
    gap_pct   = 0;
    stall_pct = 0;
    configure(13'h1FFF, 13'd255);
    hold_request = 1'b1;
    send_frames(300, 2);

    configure(SpanW'($urandom_range(1, 16)), SpanW'($urandom));
    send_frames(300, 8);

    // a long bright row, then a dark row after it
    configure(13'd4096, 13'd225);
    send_row(3, 4'hF, 12'h010, 1'b1);
    send_row(24, 4'hF, 12'h011, 1'b0);
    send_row(1, 4'h0, 12'h012, 1'b0);
    send_row(2, 4'hF, 12'h013, 1'b0);
    send_row(1, 4'h1, 12'h014, 1'b0);
    send_row(1, 4'hF, 12'h015, 1'b0);

    drain();
    if (lines_sb.mismatches == 0 && lines_sb.expected_lines.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rpmd_pkg.sv
hw/rtl/row_profile_minimum_detector.sv
dv/row_profile_minimum_detector_test.sv
